// ----- design/erm_pkg.sv -----
// ----------------------------------------------------------------------------
// erm_pkg: shared types and constants for the exponential regret matching block
// Word layouts, sequencer states, register map and the exp bit table.
// ----------------------------------------------------------------------------
`default_nettype none

package erm_pkg;

  localparam int MAX_ACTIONS_DEF = 16;

  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;
  localparam int LAMBDA_W = 16;
  localparam int REGRET_W = 32;
  localparam int PROB_W   = 17;
  localparam int AIDX_W   = 6;
  localparam int SUM_W    = 24;
  localparam int NUM_W    = 34;
  localparam int Q_W      = 20;
  localparam int ACC_W    = 33;
  localparam int EXP_W    = 32;
  localparam int PROD_W   = ACC_W + EXP_W;
  localparam int BIT_W    = 5;

  localparam logic [LAMBDA_W-1:0] LAMBDA_RESET = 16'd256;
  localparam logic [PROB_W-1:0]   ONE_Q16      = 17'd65536;
  localparam logic [ACC_W-1:0]    ACC_ONE      = 33'h1_0000_0000;
  localparam logic [BIT_W-1:0]    TOP_BIT      = 5'd19;

  // register index, taken from paddr[2]
  localparam logic REG_LAMBDA = 1'b0;

  typedef struct packed {
    logic signed [REGRET_W-1:0] regret;
    logic                       last;
  } erm_in_t;

  typedef struct packed {
    logic [PROB_W-1:0] prob;
    logic [AIDX_W-1:0] action_index;
    logic              run_end;
  } erm_out_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_START,
    ST_W_RD,
    ST_W_CHK,
    ST_W_MQ,
    ST_W_EXP,
    ST_W_MUL,
    ST_W_WR,
    ST_D_RD,
    ST_D_GO,
    ST_D_WAIT
  } erm_state_t;

  // round(2^32 * exp(-2^(b-16)))
  function automatic logic [EXP_W-1:0] exp_const(input logic [BIT_W-1:0] b);
    logic [EXP_W-1:0] e;
    case (b)
      5'd0:    e = 32'd4294901760;
      5'd1:    e = 32'd4294836226;
      5'd2:    e = 32'd4294705160;
      5'd3:    e = 32'd4294443040;
      5'd4:    e = 32'd4293918848;
      5'd5:    e = 32'd4292870656;
      5'd6:    e = 32'd4290775039;
      5'd7:    e = 32'd4286586875;
      5'd8:    e = 32'd4278222805;
      5'd9:    e = 32'd4261543595;
      5'd10:   e = 32'd4228380000;
      5'd11:   e = 32'd4162825044;
      5'd12:   e = 32'd4034748382;
      5'd13:   e = 32'd3790295335;
      5'd14:   e = 32'd3344923893;
      5'd15:   e = 32'd2605029347;
      5'd16:   e = 32'd1580030169;
      5'd17:   e = 32'd581260615;
      5'd18:   e = 32'd78665070;
      5'd19:   e = 32'd1440801;
      default: e = '0;
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

// ----- design/erm_mul.sv -----
// ----------------------------------------------------------------------------
// erm_mul: shared registered multiplier
// Serves lambda*(max-regret) and every step of the exp product chain.
// ----------------------------------------------------------------------------
`default_nettype none

module erm_mul (
  input  wire logic                       clk,
  input  wire logic [erm_pkg::ACC_W-1:0]  a,
  input  wire logic [erm_pkg::EXP_W-1:0]  b,
  output logic      [erm_pkg::PROD_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= erm_pkg::PROD_W'(a) * erm_pkg::PROD_W'(b);
  end

endmodule

`default_nettype wire

// ----- design/erm_div.sv -----
// ----------------------------------------------------------------------------
// erm_div: iterative restoring divider
// One quotient bit per cycle; the quotient is known to fit in 17 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module erm_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [erm_pkg::NUM_W-1:0]  num,
  input  wire logic [erm_pkg::SUM_W-1:0]  den,
  output logic                            busy,
  output logic      [erm_pkg::PROB_W-1:0] quot
);

  localparam int PW = erm_pkg::PROB_W;
  localparam int SW = erm_pkg::SUM_W;

  logic [SW-1:0] rem;
  logic [SW-1:0] den_r;
  logic [PW-1:0] qsh;
  logic [4:0]    step;
  logic [SW:0]   rem_sh;
  logic [SW:0]   rem_sub;
  logic          fits;

  assign rem_sh  = {rem, qsh[PW-1]};
  assign rem_sub = rem_sh - {1'b0, den_r};
  assign fits    = rem_sh >= {1'b0, den_r};
  assign quot    = qsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= 5'(PW);
    end else if (busy) begin
      step <= step - 5'd1;
      if (step == 5'd1) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // high part is below the divisor, since the quotient fits in PW bits
      rem   <= SW'(num[erm_pkg::NUM_W-1:PW]);
      qsh   <= num[PW-1:0];
      den_r <= den;
    end else if (busy) begin
      if (fits) begin
        rem <= rem_sub[SW-1:0];
        qsh <= {qsh[PW-2:0], 1'b1};
      end else begin
        rem <= rem_sh[SW-1:0];
        qsh <= {qsh[PW-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/exp_regret_matching_softmax_top.sv -----
// Sequence: regret words are taken while loading; after the last word, a start state,
//   then a weight pass (skipped with no positive regret) that writes zero for a
//   non-positive action or on exp underflow, else multiplies in one exp constant per
//   set bit of q, then a divide pass per action, held longer under output stalls.
// Throughput: one combo at a time; no regret word is taken during the passes.
// Reset: synchronous, active high; clears count, max, sum, lambda (to 1.0), valid.
// ----------------------------------------------------------------------------
// exp_regret_matching_softmax_top: softmax over positive regrets
// Buffers one combo of regrets, computes exp weights and normalizes them (uniform when they sum to zero).
// ----------------------------------------------------------------------------
`default_nettype none

module exp_regret_matching_softmax_top #(
  parameter int MAX_ACTIONS = erm_pkg::MAX_ACTIONS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        regret_valid,
  output logic                             regret_ready,
  input  wire erm_pkg::erm_in_t            regret_word,
  output logic                             prob_valid,
  input  wire logic                        prob_ready,
  output erm_pkg::erm_out_t                prob_word,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [erm_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [erm_pkg::DATA_W-1:0]  pwdata,
  output logic      [erm_pkg::DATA_W-1:0]  prdata,
  output logic                             pready
);

  localparam int IDX_W = $clog2(MAX_ACTIONS);
  localparam int CNT_W = $clog2(MAX_ACTIONS + 1);

  erm_pkg::erm_state_t state, state_next;

  logic [erm_pkg::LAMBDA_W-1:0] lambda;
  logic [CNT_W-1:0]             count;
  logic signed [erm_pkg::REGRET_W-1:0] max_pos;
  logic [erm_pkg::SUM_W-1:0]    sum;
  logic [IDX_W-1:0]             idx;
  logic [erm_pkg::Q_W-1:0]      qreg;
  logic [erm_pkg::ACC_W-1:0]    acc;
  logic [erm_pkg::BIT_W-1:0]    bitn;
  logic [erm_pkg::PROB_W-1:0]   weight;

  logic [erm_pkg::REGRET_W-1:0] regret_mem [MAX_ACTIONS];
  logic [erm_pkg::PROB_W-1:0]   weight_mem [MAX_ACTIONS];
  logic [erm_pkg::REGRET_W-1:0] reg_rd;
  logic [erm_pkg::PROB_W-1:0]   w_rd;

  logic                          take;
  logic                          store_en;
  logic                          last_idx;
  logic                          reg_pos;
  logic                          uniform;
  logic                          out_free;
  logic [erm_pkg::REGRET_W-1:0]  diff;
  logic [erm_pkg::ACC_W-1:0]     mul_a;
  logic [erm_pkg::EXP_W-1:0]     mul_b;
  logic [erm_pkg::PROD_W-1:0]    prod;
  logic [erm_pkg::ACC_W-1:0]     rnd_src;
  logic [erm_pkg::ACC_W-1:0]     rnd_sum;
  logic                          div_start;
  logic                          div_busy;
  logic [erm_pkg::NUM_W-1:0]     div_num;
  logic [erm_pkg::SUM_W-1:0]     div_den;
  logic [erm_pkg::PROB_W-1:0]    div_quot;

  // configuration port
  assign pready = 1'b1;

  always_comb begin
    prdata = '0;
    if (paddr[2] == erm_pkg::REG_LAMBDA) begin
      prdata = erm_pkg::DATA_W'(lambda);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lambda <= erm_pkg::LAMBDA_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == erm_pkg::REG_LAMBDA) begin
      lambda <= pwdata[erm_pkg::LAMBDA_W-1:0];
    end
  end

  assign take     = regret_valid && regret_ready;
  assign store_en = take && (count < CNT_W'(MAX_ACTIONS));
  assign last_idx = (CNT_W'(idx) == count - CNT_W'(1));
  assign reg_pos  = !reg_rd[erm_pkg::REGRET_W-1] && (reg_rd != '0);
  assign diff     = max_pos - reg_rd;
  assign uniform  = (max_pos == '0) || (sum == '0);
  assign out_free = !prob_valid || prob_ready;

  // buffers
  always_ff @(posedge clk) begin
    if (store_en) begin
      regret_mem[count[IDX_W-1:0]] <= regret_word.regret;
    end
    reg_rd <= regret_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (state == erm_pkg::ST_W_WR) begin
      weight_mem[idx] <= weight;
    end
    w_rd <= weight_mem[idx];
  end

  // shared multiplier
  always_comb begin
    if (state == erm_pkg::ST_W_CHK) begin
      mul_a = erm_pkg::ACC_W'(diff);
      mul_b = erm_pkg::EXP_W'(lambda);
    end else begin
      mul_a = acc;
      mul_b = erm_pkg::exp_const(bitn);
    end
  end

  erm_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  assign rnd_src = (state == erm_pkg::ST_W_MUL) ?
                   prod[erm_pkg::PROD_W-1:erm_pkg::EXP_W] : acc;
  assign rnd_sum = rnd_src + erm_pkg::ACC_W'(32768);

  // divider
  assign div_start = (state == erm_pkg::ST_D_GO);

  always_comb begin
    if (uniform) begin
      div_num = erm_pkg::NUM_W'(erm_pkg::ONE_Q16) + erm_pkg::NUM_W'(count >> 1);
      div_den = erm_pkg::SUM_W'(count);
    end else begin
      div_num = {1'b0, w_rd, 16'b0} + erm_pkg::NUM_W'(sum >> 1);
      div_den = sum;
    end
  end

  erm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quot  (div_quot)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= erm_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    regret_ready = 1'b0;
    unique case (state)
      erm_pkg::ST_LOAD: begin
        regret_ready = 1'b1;
        if (regret_valid && regret_word.last) begin
          state_next = erm_pkg::ST_START;
        end
      end
      erm_pkg::ST_START: begin
        state_next = (max_pos != '0) ? erm_pkg::ST_W_RD : erm_pkg::ST_D_RD;
      end
      erm_pkg::ST_W_RD: begin
        state_next = erm_pkg::ST_W_CHK;
      end
      erm_pkg::ST_W_CHK: begin
        state_next = reg_pos ? erm_pkg::ST_W_MQ : erm_pkg::ST_W_WR;
      end
      erm_pkg::ST_W_MQ: begin
        state_next = (prod[47:28] != '0) ? erm_pkg::ST_W_WR : erm_pkg::ST_W_EXP;
      end
      erm_pkg::ST_W_EXP: begin
        if (qreg[bitn]) begin
          state_next = erm_pkg::ST_W_MUL;
        end else if (bitn == '0) begin
          state_next = erm_pkg::ST_W_WR;
        end
      end
      erm_pkg::ST_W_MUL: begin
        state_next = (bitn == '0) ? erm_pkg::ST_W_WR : erm_pkg::ST_W_EXP;
      end
      erm_pkg::ST_W_WR: begin
        state_next = last_idx ? erm_pkg::ST_D_RD : erm_pkg::ST_W_RD;
      end
      erm_pkg::ST_D_RD: begin
        state_next = erm_pkg::ST_D_GO;
      end
      erm_pkg::ST_D_GO: begin
        state_next = erm_pkg::ST_D_WAIT;
      end
      erm_pkg::ST_D_WAIT: begin
        if (!div_busy && out_free) begin
          state_next = last_idx ? erm_pkg::ST_LOAD : erm_pkg::ST_D_RD;
        end
      end
      default: begin
        state_next = erm_pkg::ST_LOAD;
      end
    endcase
  end

  // control counters and combo state
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      max_pos <= '0;
      sum     <= '0;
      idx     <= '0;
    end else begin
      if (store_en) begin
        count <= count + CNT_W'(1);
        if (regret_word.regret > max_pos) begin
          max_pos <= regret_word.regret;
        end
      end
      if (state == erm_pkg::ST_START) begin
        idx <= '0;
      end
      if (state == erm_pkg::ST_W_WR) begin
        sum <= sum + erm_pkg::SUM_W'(weight);
        idx <= last_idx ? '0 : IDX_W'(idx + 1'b1);
      end
      if (state == erm_pkg::ST_D_WAIT && !div_busy && out_free) begin
        if (last_idx) begin
          // close the combo
          count   <= '0;
          max_pos <= '0;
          sum     <= '0;
          idx     <= '0;
        end else begin
          idx <= IDX_W'(idx + 1'b1);
        end
      end
    end
  end

  // exp datapath
  always_ff @(posedge clk) begin
    unique case (state)
      erm_pkg::ST_W_CHK: begin
        if (!reg_pos) begin
          weight <= '0;
        end
      end
      erm_pkg::ST_W_MQ: begin
        if (prod[47:28] != '0) begin
          weight <= '0;
        end else begin
          qreg <= prod[27:8];
          acc  <= erm_pkg::ACC_ONE;
          bitn <= erm_pkg::TOP_BIT;
        end
      end
      erm_pkg::ST_W_EXP: begin
        if (!qreg[bitn]) begin
          if (bitn == '0) begin
            weight <= rnd_sum[erm_pkg::ACC_W-1:16];
          end else begin
            bitn <= bitn - 1'b1;
          end
        end
      end
      erm_pkg::ST_W_MUL: begin
        acc <= prod[erm_pkg::PROD_W-1:erm_pkg::EXP_W];
        if (bitn == '0) begin
          weight <= rnd_sum[erm_pkg::ACC_W-1:16];
        end else begin
          bitn <= bitn - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      prob_valid <= 1'b0;
    end else if (state == erm_pkg::ST_D_WAIT && !div_busy && out_free) begin
      prob_valid <= 1'b1;
    end else if (prob_ready) begin
      prob_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == erm_pkg::ST_D_WAIT && !div_busy && out_free) begin
      prob_word.prob         <= div_quot;
      prob_word.action_index <= erm_pkg::AIDX_W'(idx);
      prob_word.run_end      <= last_idx;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_ACTIONS))
    else $error("action count beyond buffer depth");

  a_max_nonneg: assert property (@(posedge clk) disable iff (rst)
    !max_pos[erm_pkg::REGRET_W-1])
    else $error("max positive regret went negative");

  a_load_from_div: assert property (@(posedge clk) disable iff (rst)
    $rose(prob_valid) |-> $past(state == erm_pkg::ST_D_WAIT))
    else $error("result word loaded outside the divide pass");

  a_combo_closed: assert property (@(posedge clk) disable iff (rst)
    (state == erm_pkg::ST_D_WAIT && state_next == erm_pkg::ST_LOAD) |=>
      (count == '0 && max_pos == '0 && sum == '0))
    else $error("combo state not cleared at close");

  a_start_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == erm_pkg::ST_START |-> count != '0)
    else $error("combo closed with no buffered action");
`endif

endmodule

`default_nettype wire

// ----- tb/tb_exp_regret_matching_softmax_top.sv -----
// ----------------------------------------------------------------------------
// tb_exp_regret_matching_softmax_top: softmax regret matching regression
// Streams combos of regrets through the block, predicts each probability with
// a local fixed-point exp and divide model, and compares every output word.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_exp_regret_matching_softmax_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NACT = erm_pkg::MAX_ACTIONS_DEF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic regret_valid = 1'b0;
  logic regret_ready;
  erm_pkg::erm_in_t regret_word = '0;
  logic prob_valid;
  logic prob_ready = 1'b0;
  erm_pkg::erm_out_t prob_word;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [erm_pkg::ADDR_W-1:0] paddr = '0;
  logic [erm_pkg::DATA_W-1:0] pwdata = '0;
  logic [erm_pkg::DATA_W-1:0] prdata;
  logic pready;

  exp_regret_matching_softmax_top dut (
    .clk(clk), .rst(rst),
    .regret_valid(regret_valid), .regret_ready(regret_ready), .regret_word(regret_word),
    .prob_valid(prob_valid), .prob_ready(prob_ready), .prob_word(prob_word),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [15:0] gain_q88 = 16'd256;
  logic signed [31:0] held_regret [NACT];
  int unsigned held_count = 0;
  logic signed [31:0] top_regret = 0;
  erm_pkg::erm_out_t prob_fifo [$];
  int unsigned errors = 0;
  int unsigned words_checked = 0;
  int unsigned combos_sent = 0;
  bit rand_stall = 1'b1;

  function automatic logic [31:0] exp_bit(input int b);
    case (b)
      0: return 32'd4294901760;   1: return 32'd4294836226;
      2: return 32'd4294705160;   3: return 32'd4294443040;
      4: return 32'd4293918848;   5: return 32'd4292870656;
      6: return 32'd4290775039;   7: return 32'd4286586875;
      8: return 32'd4278222805;   9: return 32'd4261543595;
      10: return 32'd4228380000;  11: return 32'd4162825044;
      12: return 32'd4034748382;  13: return 32'd3790295335;
      14: return 32'd3344923893;  15: return 32'd2605029347;
      16: return 32'd1580030169;  17: return 32'd581260615;
      18: return 32'd78665070;    default: return 32'd1440801;
    endcase
  endfunction

  function automatic logic [16:0] softmax_weight(input logic signed [31:0] r,
                                                 input logic signed [31:0] mx,
                                                 input logic [15:0] g);
    logic [63:0] diff;
    logic [63:0] q;
    logic [63:0] acc;
    diff = 64'(signed'(mx)) - 64'(signed'(r));
    q = (64'(g) * diff) >> 8;
    acc = 64'h1_0000_0000;
    if (q >= 64'h10_0000) return '0;
    for (int b = 19; b >= 0; b--)
      if (q[b]) acc = (acc * 64'(exp_bit(b))) >> 32;
    return 17'((acc + 64'd32768) >> 16);
  endfunction

  // absorb one accepted regret and queue the combo's probabilities on last
  task automatic predict_regret(input erm_pkg::erm_in_t w);
    logic [16:0] wt [NACT];
    logic [23:0] total;
    logic [63:0] p;
    erm_pkg::erm_out_t o;
    if (held_count < NACT) begin
      held_regret[held_count] = w.regret;
      if (w.regret > top_regret) top_regret = w.regret;
      held_count++;
    end
    if (!w.last) return;
    total = '0;
    for (int i = 0; i < held_count; i++) begin
      wt[i] = (top_regret > 0 && held_regret[i] > 0) ?
              softmax_weight(held_regret[i], top_regret, gain_q88) : '0;
      total = total + 24'(wt[i]);
    end
    for (int i = 0; i < held_count; i++) begin
      if (top_regret > 0 && total != 0)
        p = (64'(wt[i]) * 64'd65536 + 64'(total / 2)) / 64'(total);
      else
        p = (64'd65536 + 64'(held_count / 2)) / 64'(held_count);
      o.prob = 17'(p);
      o.action_index = 6'(i);
      o.run_end = (i + 1 == held_count);
      prob_fifo.push_back(o);
    end
    held_count = 0;
    top_regret = 0;
    combos_sent++;
  endtask

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 50) return 0;
    if (k < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // valid stays up after an accept only until the caller drives again in the
  // same step, so back to back words never see a second assignment
  task automatic send_regret(input logic signed [31:0] r, input logic lst);
    erm_pkg::erm_in_t w;
    int g;
    w.regret = r;
    w.last = lst;
    g = rand_stall ? gap_len() : 0;
    if (g > 0) begin
      regret_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    regret_valid <= 1'b1;
    regret_word <= w;
    do @(posedge clk); while (!regret_ready);
    predict_regret(w);
  endtask

  // wait for every queued probability, then let the passes drain
  task automatic drain();
    regret_valid <= 1'b0;
    while (prob_fifo.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_gain(input logic [15:0] g);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {erm_pkg::REG_LAMBDA, 2'b00}; pwdata <= 32'(g);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    gain_q88 = g;
  endtask

  task automatic send_combo(input int n, input int mode);
    logic signed [31:0] r;
    for (int i = 0; i < n; i++) begin
      case (mode)
        0: r = $urandom();
        1: r = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0002_0000;
        default: r = -$signed({1'b0, 31'($urandom())});
      endcase
      send_regret(r, i == n - 1);
    end
  endtask

  task automatic test_extremes();
    send_regret(32'sh7fff_ffff, 1'b0);
    send_regret(32'sh8000_0000, 1'b0);
    send_regret(32'sh0000_0001, 1'b0);
    send_regret(32'sh0001_0000, 1'b1);
    send_regret(32'sh0000_0000, 1'b1);      // single non-positive action
    send_regret(-32'sd5, 1'b0);
    send_regret(32'sh8000_0000, 1'b1);      // no positive regret: uniform
    send_regret(32'sh0001_0000, 1'b0);
    send_regret(32'sh0001_0000, 1'b1);      // ties
    drain();
  endtask

  task automatic test_gain_settings();
    logic [15:0] gains [4] = '{16'd1, 16'd65535, 16'd0, 16'd4096};
    foreach (gains[k]) begin
      write_gain(gains[k]);
      send_combo(3, 1);
      send_combo(2, 0);
      drain();
    end
    write_gain(16'd256);
  endtask

  task automatic test_overflow();
    // more actions than the buffer holds; the extras are dropped
    send_combo(NACT + 3, 1);
    drain();
  endtask

  task automatic test_random();
    int sent;
    int n;
    sent = 0;
    while (sent < 230) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(NACT, NACT + 2)
                                      : $urandom_range(1, 6);
      send_combo(n, $urandom_range(0, 9) < 7 ? 1 : $urandom_range(0, 2));
      sent += n;
      if ($urandom_range(0, 19) == 0) drain();
      if ($urandom_range(0, 29) == 0) begin
        drain();
        write_gain(16'($urandom_range(1, 65535)));
      end
      if (sent > 150) rand_stall = 1'b0;
    end
    rand_stall = 1'b1;
    drain();
  endtask

  // output side: random stalls and word compare
  always @(posedge clk) begin
    if (rst) begin
      prob_ready <= 1'b0;
    end else begin
      if (prob_valid && prob_ready) begin
        if (prob_fifo.size() == 0) begin
          $error("unexpected word %p", prob_word);
          errors++;
        end else begin
          erm_pkg::erm_out_t e;
          e = prob_fifo.pop_front();
          if (prob_word.prob !== e.prob) begin
            $error("prob exp %0d got %0d", e.prob, prob_word.prob); errors++;
          end
          if (prob_word.action_index !== e.action_index) begin
            $error("action_index exp %0d got %0d", e.action_index,
                   prob_word.action_index); errors++;
          end
          if (prob_word.run_end !== e.run_end) begin
            $error("run_end exp %0d got %0d", e.run_end, prob_word.run_end); errors++;
          end
          words_checked++;
        end
      end
      prob_ready <= rand_stall ? ($urandom_range(0, 9) > 2) : 1'b1;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_gain_settings();
    test_overflow();
    test_random();
    if (prob_fifo.size() != 0) begin
      $error("%0d probabilities never arrived", prob_fifo.size());
      errors++;
    end
    $display("covered %0d combos, %0d probability words compared", combos_sent,
             words_checked);
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #50ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

`default_nettype wire
